### hdl/bdl_pkg.sv
// Shared types and constants for the button debounce and lockout block.
// Used by bdl_eval and button_debounce_lockout; no dependencies.
package bdl_pkg;

	// Item kinds on the input channel.
	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Pin levels (active low buttons).
	localparam logic LEVEL_PRESSED  = 1'b0;
	localparam logic LEVEL_RELEASED = 1'b1;

	// Configuration register indexes.
	localparam logic REG_RELEASE_LOCKOUT = 1'b0;
	localparam logic REG_PRESS_LOCKOUT   = 1'b1;

	localparam logic [15:0] LOCKOUT_RESET = 16'd50;
	localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

	// One per-button table entry.
	typedef struct packed {
		logic        down;
		logic [31:0] stamp;
	} bdl_entry_t;

	// One result beat.
	typedef struct packed {
		logic        pressed;
		logic        released;
		logic [31:0] held_ms;
	} bdl_result_t;

endpackage

### hdl/bdl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bdl_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/bdl_eval.sv
// Lockout qualification for one button sample: decides whether a state change
// is taken and builds the result beat. Depends on bdl_pkg.
module bdl_eval import bdl_pkg::*; (
	input  bdl_entry_t  cur,
	input  logic        level,
	input  logic [31:0] now_ms,
	input  logic [31:0] duration,
	input  logic [15:0] release_lockout,
	input  logic [15:0] press_lockout,
	output logic        change,
	output bdl_entry_t  nxt,
	output bdl_result_t res
);

	logic [31:0] elapsed;
	logic [31:0] lockout;

	// Time since the last accepted change, modulo 2^32.
	assign elapsed = now_ms - cur.stamp;
	assign lockout = cur.down ? {16'd0, release_lockout} : {16'd0, press_lockout};

	// A change needs an expired lockout and the opposite pin level.
	always_comb begin
		if (cur.down) begin
			change = (elapsed > lockout) && (level == LEVEL_RELEASED);
		end else begin
			change = (elapsed > lockout) && (level == LEVEL_PRESSED);
		end
		nxt.down  = ~cur.down;
		nxt.stamp = now_ms;
		res.pressed  = change && !cur.down;
		res.released = change && cur.down;
		res.held_ms  = (change && cur.down) ? duration : 32'd0;
	end

endmodule

### hdl/button_debounce_lockout.sv
// Multi-channel pushbutton qualifier with press and release lockout times.
// Depends on bdl_pkg, bdl_ram and bdl_eval.
//
// Usage: the input channel carries tick beats (mode 0, one per millisecond)
// and sample beats (mode 1, a button index and its active-low level). Each
// sample beat yields exactly one result beat; ticks yield none. Per-button
// state (down flag and time of last change) sits in a RAM with registered
// read data; the read is issued when a beat is accepted and the table is
// updated when the beat leaves stage 1, with a bypass for back-to-back
// samples of the same button. A result passes through the stage 1 register
// and then the output register before it can be taken.
// Throughput is one beat per cycle while out_ready is high. When the
// receiver stalls, one finished result waits in the output register and one
// more beat can wait behind it; in_ready then drops.
// Reset clears the clocks, the lockouts to 50 ms and all per-button entries
// at once (per-entry valid flags), so beats are taken right after reset. The
// user makes configuration writes while idle, unchecked; they act at once.
module button_debounce_lockout import bdl_pkg::*; #(
	parameter int NUM_BUTTONS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [5:0]  button,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pressed,
	output logic        released,
	output logic [31:0] held_ms
);

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int EW = $bits(bdl_entry_t);

	logic [15:0] rel_lock_q;
	logic [15:0] prs_lock_q;
	logic [31:0] now_q;
	logic [31:0] dur_q;
	logic [NUM_BUTTONS-1:0] ent_vld_q;

	logic          vld_s1;
	logic          mode_s1;
	logic          level_s1;
	logic [AW-1:0] addr_s1;
	logic          inrange_s1;
	logic          fwd_hit_s1;
	bdl_entry_t    fwd_data_s1;

	logic        out_vld_q;
	bdl_result_t out_q;

	logic          in_acc;
	logic          out_free;
	logic          s1_go;
	logic [AW-1:0] in_addr;
	logic [EW-1:0] ram_rdata;
	bdl_entry_t    cur_ent;
	bdl_entry_t    nxt_ent;
	logic          change;
	bdl_result_t   res;
	logic          wr_en;

	// Handshake: stage 1 moves on unless a sample finds the output full.
	assign out_free = !out_vld_q || out_ready;
	assign s1_go    = vld_s1 && ((mode_s1 == MODE_TICK) || out_free);
	assign in_ready = !vld_s1 || s1_go;
	assign in_acc   = in_valid && in_ready;
	assign in_addr  = AW'(button);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_lock_q <= LOCKOUT_RESET;
			prs_lock_q <= LOCKOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RELEASE_LOCKOUT: rel_lock_q <= cfg_data;
				REG_PRESS_LOCKOUT:   prs_lock_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	// Per-button table.
	bdl_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_BUTTONS)
	) u_tab (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(nxt_ent),
		.re   (in_acc),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Stage 1 payload, plus a bypass for a write landing on the entry being read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1     <= mode;
			level_s1    <= level;
			addr_s1     <= in_addr;
			inrange_s1  <= (32'(button) < NUM_BUTTONS);
			fwd_hit_s1  <= wr_en && (addr_s1 == in_addr);
			fwd_data_s1 <= nxt_ent;
		end
	end

	// Current entry: bypass first, then RAM data if the entry was ever written.
	always_comb begin
		if (fwd_hit_s1) begin
			cur_ent = fwd_data_s1;
		end else if (inrange_s1 && ent_vld_q[addr_s1]) begin
			cur_ent = bdl_entry_t'(ram_rdata);
		end else begin
			cur_ent = '0;
		end
	end

	bdl_eval u_eval (
		.cur            (cur_ent),
		.level          (level_s1),
		.now_ms         (now_q),
		.duration       (dur_q),
		.release_lockout(rel_lock_q),
		.press_lockout  (prs_lock_q),
		.change         (change),
		.nxt            (nxt_ent),
		.res            (res)
	);

	assign wr_en = s1_go && (mode_s1 == MODE_SAMPLE) && inrange_s1 && change;

	// Entry valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[addr_s1] <= 1'b1;
		end
	end

	// Millisecond clock and shared press duration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			dur_q <= '0;
		end else if (s1_go && (mode_s1 == MODE_TICK)) begin
			now_q <= now_q + 32'd1;
			if (dur_q != COUNT_MAX) begin
				dur_q <= dur_q + 32'd1;
			end
		end else if (wr_en && res.pressed) begin
			dur_q <= '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go && (mode_s1 == MODE_SAMPLE)) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (mode_s1 == MODE_SAMPLE)) begin
			out_q <= inrange_s1 ? res : '0;
		end
	end

	assign out_valid = out_vld_q;
	assign pressed   = out_q.pressed;
	assign released  = out_q.released;
	assign held_ms   = out_q.held_ms;

`ifndef ASSERT_OFF
	// A result never reports both edges, and a press never carries a held time.
	a_one_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pressed && released) && (pressed ? held_ms == 32'd0 : 1'b1))
		else $error("result flags both edges or press with held time");

	// The table is only written by an in-range sample leaving stage 1.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> vld_s1 && (mode_s1 == MODE_SAMPLE) && inrange_s1 && out_free)
		else $error("table write without a qualifying sample");

	// An accepted press clears the duration counter.
	a_press_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && res.pressed) |=> dur_q == 32'd0)
		else $error("duration not cleared after press");

	// A tick advances the millisecond clock by one.
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (mode_s1 == MODE_TICK)) |=> now_q == $past(now_q) + 32'd1)
		else $error("millisecond clock did not advance on tick");

	// A stalled sample in stage 1 blocks new input.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (mode_s1 == MODE_SAMPLE) && !out_free) |-> !in_ready)
		else $error("input taken while stage 1 stalled");
`endif

endmodule
